>>> hdl/gnms_pkg.sv
// Shared constants and types for the gradient non-maximum suppression block.
// No dependencies.
package gnms_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
    localparam int MAG_BITS   = 16;
    localparam int DIR_BITS   = 15;
    localparam int GRAY_BITS  = 8;
    localparam int CFG_BITS   = 12;
    localparam int ROW_BITS   = CFG_BITS + 1;
    localparam int DG_BITS    = DIR_BITS + GRAY_BITS;
    localparam int ENTRY_BITS = 2 * MAG_BITS + DG_BITS;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = PTR_BITS + 1;

    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET   = 12'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic [CFG_BITS-1:0] MIN_SIZE           = 12'd3;
    localparam logic [CFG_BITS-1:0] MAX_LINE           = CFG_BITS'(MAX_WIDTH);

    // Sector boundaries pi/8, 3pi/8, 5pi/8, 7pi/8 in Q3.12, truncated
    localparam logic [DIR_BITS:0] T_PI8_1 = 16'd1608;
    localparam logic [DIR_BITS:0] T_PI8_3 = 16'd4825;
    localparam logic [DIR_BITS:0] T_PI8_5 = 16'd8042;
    localparam logic [DIR_BITS:0] T_PI8_7 = 16'd11259;

    typedef enum logic {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]  mag;
        logic [GRAY_BITS-1:0] gray;
        logic                 supp;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic                 border;
        logic                 last;
        logic [ADDR_BITS-1:0] addr;
    } s1_ctrl_t;

endpackage

>>> hdl/gradient_non_max_suppression.sv
// Top level of the gradient non-maximum suppression block.
// Depends on gnms_pkg.
//
// One pixel is taken per clock while the output queue has room. Line storage is
// a single 2048-entry memory, one entry per column, holding the two previous
// magnitude rows and the direction and gray of the previous row; each accepted
// pixel reads its column in the accept cycle and writes it back the next cycle.
// Two pixels in a row hit the same column only across a frame boundary; the
// written word is then forwarded to the second read.
// The result of the pixel that completes a window is computed in stage 1 and
// written to the output queue; the result for pixel q follows input item q+W+1.
// in_stall rises when the four-entry output queue plus the pixel in flight
// would fill. A frame is W*H pixels plus W+1 flush items; the last flush item
// yields the result marked frame_last. Padding items during the pixel phase are
// accepted and dropped. A register write restarts the frame. Border rows and
// columns pass unchanged.
module gradient_non_max_suppression (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gnms_pkg::MAG_BITS-1:0]       grad_mag,
    input  logic signed [gnms_pkg::DIR_BITS-1:0] grad_dir,
    input  logic [gnms_pkg::GRAY_BITS-1:0]      gray_in,
    input  logic                                is_padding,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gnms_pkg::MAG_BITS-1:0]       mag_out,
    output logic [gnms_pkg::GRAY_BITS-1:0]      gray_out,
    output logic                                suppressed,
    output logic                                frame_last
);

    // configuration
    logic [gnms_pkg::CFG_BITS-1:0] line_width_reg;
    logic [gnms_pkg::CFG_BITS-1:0] frame_height_reg;
    logic                          cfg_write;
    gnms_pkg::reg_index_t          cfg_sel;
    logic [gnms_pkg::CFG_BITS-1:0] w_eff;
    logic [gnms_pkg::CFG_BITS-1:0] h_eff;

    // stage 0
    logic [gnms_pkg::ADDR_BITS-1:0] col_cnt_reg, col_cnt_next;
    logic [gnms_pkg::ROW_BITS-1:0]  row_cnt_reg, row_cnt_next;
    logic                           accept;
    logic                           flushing;
    logic                           take;
    logic [gnms_pkg::ADDR_BITS-1:0] col;
    logic [gnms_pkg::CFG_BITS-1:0]  col_plus;
    logic                           emit;
    logic [gnms_pkg::ROW_BITS-1:0]  c_row;
    logic [gnms_pkg::ADDR_BITS-1:0] c_col;
    logic [gnms_pkg::ROW_BITS-1:0]  h_last;
    logic [gnms_pkg::ADDR_BITS-1:0] w_last;
    logic                           border;
    logic                           last;

    // stage 1
    gnms_pkg::s1_ctrl_t             s1_reg;
    logic [gnms_pkg::MAG_BITS-1:0]  s1_mag_reg;
    logic [gnms_pkg::DG_BITS-1:0]   s1_dg_reg;
    logic [gnms_pkg::ENTRY_BITS-1:0] rd_data_reg;
    logic                           fwd_reg;
    logic [gnms_pkg::ENTRY_BITS-1:0] fwd_data_reg;
    logic [gnms_pkg::ENTRY_BITS-1:0] rd_word;
    logic [gnms_pkg::ENTRY_BITS-1:0] wr_data;
    logic [gnms_pkg::ENTRY_BITS-1:0] line_mem [gnms_pkg::MAX_WIDTH];
    logic [gnms_pkg::MAG_BITS-1:0]  rd_top;
    logic [gnms_pkg::MAG_BITS-1:0]  rd_mid;
    logic [gnms_pkg::MAG_BITS-1:0]  win_reg  [9];
    logic [gnms_pkg::MAG_BITS-1:0]  win_next [9];
    logic [gnms_pkg::DG_BITS-1:0]   hold_reg;
    logic signed [gnms_pkg::DIR_BITS:0] dir_ext;
    logic [gnms_pkg::DIR_BITS:0]    dir_abs;
    logic [gnms_pkg::MAG_BITS-1:0]  p1;
    logic [gnms_pkg::MAG_BITS-1:0]  p2;
    logic                           supp;
    gnms_pkg::result_t              result;
    logic                           push;

    // output queue
    gnms_pkg::result_t              fifo_reg [gnms_pkg::FIFO_DEPTH];
    logic [gnms_pkg::PTR_BITS-1:0]  wr_ptr_reg;
    logic [gnms_pkg::PTR_BITS-1:0]  rd_ptr_reg;
    logic [gnms_pkg::CNT_BITS-1:0]  count_reg;
    logic [gnms_pkg::CNT_BITS-1:0]  count_ahead;
    logic                           pop;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = gnms_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_sel)
            gnms_pkg::REG_LINE_WIDTH:   prdata = {20'd0, line_width_reg};
            gnms_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, frame_height_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= gnms_pkg::LINE_WIDTH_RESET;
            frame_height_reg <= gnms_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                gnms_pkg::REG_LINE_WIDTH:   line_width_reg   <= pwdata[gnms_pkg::CFG_BITS-1:0];
                gnms_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[gnms_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (line_width_reg < gnms_pkg::MIN_SIZE)
            w_eff = gnms_pkg::MIN_SIZE;
        else if (line_width_reg > gnms_pkg::MAX_LINE)
            w_eff = gnms_pkg::MAX_LINE;
        else
            w_eff = line_width_reg;
        h_eff = (frame_height_reg < gnms_pkg::MIN_SIZE) ? gnms_pkg::MIN_SIZE : frame_height_reg;
    end

    // stage 0: position, window validity, border flags
    assign count_ahead = count_reg + gnms_pkg::CNT_BITS'(s1_reg.valid);
    assign in_stall    = (count_ahead >= gnms_pkg::CNT_BITS'(gnms_pkg::FIFO_DEPTH));
    assign accept      = in_valid && !in_stall;
    assign flushing    = (row_cnt_reg >= {1'b0, h_eff});
    assign take        = accept && (flushing || !is_padding);

    always_comb
    begin
        col      = ({1'b0, col_cnt_reg} >= w_eff) ? '0 : col_cnt_reg;
        col_plus = {1'b0, col} + 12'd1;
        h_last   = {1'b0, h_eff} - 13'd1;
        w_last   = gnms_pkg::ADDR_BITS'(w_eff - 12'd1);
        if (col != '0)
        begin
            emit  = (row_cnt_reg >= 13'd1);
            c_row = row_cnt_reg - 13'd1;
            c_col = col - 11'd1;
        end
        else
        begin
            emit  = (row_cnt_reg >= 13'd2);
            c_row = row_cnt_reg - 13'd2;
            c_col = w_last;
        end
        border = (c_row == '0) || (c_row == h_last) || (c_col == '0) || (c_col == w_last);
        last   = (c_row == h_last) && (c_col == w_last);

        if (col_plus >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_cnt_reg + 13'd1;
        end
        else
        begin
            col_cnt_next = gnms_pkg::ADDR_BITS'(col_plus);
            row_cnt_next = row_cnt_reg;
        end
        if (emit && last)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            s1_reg      <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end
            else if (take)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            s1_reg.valid  <= take;
            s1_reg.emit   <= take && emit;
            s1_reg.border <= border;
            s1_reg.last   <= last;
            s1_reg.addr   <= col;
            fwd_reg       <= take && s1_reg.valid && (s1_reg.addr == col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_mag_reg <= flushing ? '0 : grad_mag;
            s1_dg_reg  <= flushing ? '0 : {grad_dir, gray_in};
        end
    end

    // line memory: read in stage 0, write back in stage 1
    assign rd_word = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign rd_top  = rd_word[gnms_pkg::ENTRY_BITS-1 -: gnms_pkg::MAG_BITS];
    assign rd_mid  = rd_word[gnms_pkg::DG_BITS +: gnms_pkg::MAG_BITS];
    assign wr_data = {rd_mid, s1_mag_reg, s1_dg_reg};

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_data_reg  <= line_mem[col];
            fwd_data_reg <= wr_data;
        end
        if (s1_reg.valid)
            line_mem[s1_reg.addr] <= wr_data;
    end

    // stage 1: window shift, sector choice, compare
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_mag_reg;

        dir_ext = {hold_reg[gnms_pkg::DG_BITS-1],
                   hold_reg[gnms_pkg::DG_BITS-1 -: gnms_pkg::DIR_BITS]};
        dir_abs = dir_ext[gnms_pkg::DIR_BITS] ? 16'(-dir_ext) : 16'(dir_ext);

        if (dir_abs <= gnms_pkg::T_PI8_1 || dir_abs > gnms_pkg::T_PI8_7)
        begin
            p1 = win_next[3];
            p2 = win_next[5];
        end
        else if ((dir_abs <= gnms_pkg::T_PI8_3 && !dir_ext[gnms_pkg::DIR_BITS] && dir_abs != '0)
              || (dir_abs > gnms_pkg::T_PI8_5 && dir_ext[gnms_pkg::DIR_BITS]))
        begin
            p1 = win_next[2];
            p2 = win_next[6];
        end
        else if (dir_abs > gnms_pkg::T_PI8_3 && dir_abs <= gnms_pkg::T_PI8_5)
        begin
            p1 = win_next[1];
            p2 = win_next[7];
        end
        else
        begin
            p1 = win_next[0];
            p2 = win_next[8];
        end

        supp        = !s1_reg.border && ((win_next[4] <= p1) || (win_next[4] <= p2));
        result.mag  = supp ? '0 : win_next[4];
        result.gray = supp ? '0 : hold_reg[gnms_pkg::GRAY_BITS-1:0];
        result.supp = supp;
        result.last = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            hold_reg <= '0;
        end
        else if (s1_reg.valid)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
            hold_reg <= rd_word[gnms_pkg::DG_BITS-1:0];
        end
    end

    // output queue
    assign push       = s1_reg.valid && s1_reg.emit;
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign mag_out    = fifo_reg[rd_ptr_reg].mag;
    assign gray_out   = fifo_reg[rd_ptr_reg].gray;
    assign suppressed = fifo_reg[rd_ptr_reg].supp;
    assign frame_last = fifo_reg[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + gnms_pkg::CNT_BITS'(push) - gnms_pkg::CNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= result;
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == gnms_pkg::CNT_BITS'(gnms_pkg::FIFO_DEPTH)))
        else $error("output queue overflow");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == gnms_pkg::CNT_BITS'(gnms_pkg::FIFO_DEPTH)) |-> in_stall)
        else $error("input not stalled while the output queue is full");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && last && !cfg_write) |=> (col_cnt_reg == '0 && row_cnt_reg == '0))
        else $error("counters did not wrap after the last pixel of the frame");

endmodule
